// ===== sv/cppc_pkg.sv =====
// Package for the convex planar polygon checker: status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package cppc_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FEW       = 3'd1,
    ST_DUP       = 3'd2,
    ST_DEGEN     = 3'd3,
    ST_NONPLANAR = 3'd4,
    ST_CONCAVE   = 3'd5,
    ST_MANY      = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_LOAD,   // taking vertices
    S_DUPRD,  // issue read for duplicate check
    S_DUP,    // compare adjacent pair
    S_NRM,    // try candidate normal
    S_PLN,    // planarity dot
    S_EDGE,   // fetch edge endpoints
    S_CVX,    // cross, then dot with normal
    S_DONE,   // result ready to latch
    S_OUT     // result waits for transfer
  } state_e;

  localparam int unsigned VertexScale = 256;
  localparam int unsigned CoordW = $clog2(VertexScale + 1);
  localparam int unsigned DiffW  = CoordW + 1;      // signed difference of two coordinates
  localparam int unsigned CrossW = 2 * DiffW + 1;   // cross of two differences
  localparam int unsigned DotW   = 2 * CrossW + 6;  // dot of two crosses, with headroom
  localparam int unsigned NormW  = 19;

endpackage

// ===== sv/cppc_vec_unit.sv =====
// Shared vector unit: cross product (or pass-through of b), then dot with n,
// over two registered stages. Depends on cppc_pkg.
`timescale 1ns / 1ps
module cppc_vec_unit (
  input  logic                                clk_i,
  input  logic                                dot_mode_i,
  input  logic signed [cppc_pkg::DiffW-1:0]   a_x_i,
  input  logic signed [cppc_pkg::DiffW-1:0]   a_y_i,
  input  logic signed [cppc_pkg::DiffW-1:0]   a_z_i,
  input  logic signed [cppc_pkg::DiffW-1:0]   b_x_i,
  input  logic signed [cppc_pkg::DiffW-1:0]   b_y_i,
  input  logic signed [cppc_pkg::DiffW-1:0]   b_z_i,
  input  logic signed [cppc_pkg::CrossW-1:0]  n_x_i,
  input  logic signed [cppc_pkg::CrossW-1:0]  n_y_i,
  input  logic signed [cppc_pkg::CrossW-1:0]  n_z_i,
  output logic signed [cppc_pkg::CrossW-1:0]  c_x_o,
  output logic signed [cppc_pkg::CrossW-1:0]  c_y_o,
  output logic signed [cppc_pkg::CrossW-1:0]  c_z_o,
  output logic signed [cppc_pkg::DotW-1:0]    dot_o
);
  import cppc_pkg::*;

  logic signed [2*DiffW-1:0]  p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [2*CrossW-1:0] q_x, q_y, q_z;
  logic signed [CrossW-1:0]   cx_q, cy_q, cz_q;
  logic signed [DotW-1:0]     dot_q;

  // Pairwise products of the operand vectors, full width.
  always_comb begin
    p_yz = a_y_i * b_z_i;
    p_zy = a_z_i * b_y_i;
    p_zx = a_z_i * b_x_i;
    p_xz = a_x_i * b_z_i;
    p_xy = a_x_i * b_y_i;
    p_yx = a_y_i * b_x_i;
  end

  // Stage 1: cross a x b, or b alone for a plain dot, registered.
  always_ff @(posedge clk_i) begin
    if (dot_mode_i) begin
      cx_q <= CrossW'(b_x_i);
      cy_q <= CrossW'(b_y_i);
      cz_q <= CrossW'(b_z_i);
    end else begin
      cx_q <= CrossW'(p_yz) - CrossW'(p_zy);
      cy_q <= CrossW'(p_zx) - CrossW'(p_xz);
      cz_q <= CrossW'(p_xy) - CrossW'(p_yx);
    end
  end

  // Products of the registered vector with n, full width.
  always_comb begin
    q_x = cx_q * n_x_i;
    q_y = cy_q * n_y_i;
    q_z = cz_q * n_z_i;
  end

  // Stage 2: dot of the registered vector with n.
  always_ff @(posedge clk_i) begin
    dot_q <= DotW'(q_x) + DotW'(q_y) + DotW'(q_z);
  end

  assign c_x_o = cx_q;
  assign c_y_o = cy_q;
  assign c_z_o = cz_q;
  assign dot_o = dot_q;
endmodule

// ===== sv/convex_planar_polygon_checker_core.sv =====
// Top level of the convex planar polygon checker: vertex store, sequencer, result register.
// Depends on cppc_pkg and cppc_vec_unit.
//
// Usage: vertices arrive on the input channel (vert_*_i, last_vertex_i) under
// in_valid_i / in_stall_o, one per cycle while loading. A transfer with
// last_vertex_i set starts the check; one result (check_status_o, normal_*_o)
// then appears under out_valid_o / out_stall_i. The input stalls from the
// last vertex until the result is transferred.
// After the last vertex the check runs a duplicate pass, a normal search,
// a planarity pass and a convexity sweep, in that order; the sweep, which
// tests every edge against every stored vertex through the one shared
// cross/dot unit (two registered stages), takes the longest.
// The store has one read port per operand, data registered.
// Reset clears the count, overflow flag and sequencer; store contents are
// left alone. While the receiver stalls the result holds.
`timescale 1ns / 1ps
module convex_planar_polygon_checker_core #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [cppc_pkg::CoordW-1:0]        vert_x_i,
  input  logic [cppc_pkg::CoordW-1:0]        vert_y_i,
  input  logic [cppc_pkg::CoordW-1:0]        vert_z_i,
  input  logic                               last_vertex_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         check_status_o,
  output logic signed [cppc_pkg::NormW-1:0]  normal_x_o,
  output logic signed [cppc_pkg::NormW-1:0]  normal_y_o,
  output logic signed [cppc_pkg::NormW-1:0]  normal_z_o
);
  import cppc_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_VERTICES);
  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);

  typedef logic [3*CoordW-1:0] vtx_t;

  vtx_t store_mem [MAX_VERTICES];
  vtx_t rd_a_q, rd_b_q;
  logic [IdxW-1:0] ra_idx, rb_idx;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic ovf_q, ovf_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [1:0] ph_q, ph_d;
  vtx_t es_q, es_d;
  logic signed [DiffW-1:0] ed_x_q, ed_y_q, ed_z_q, ed_x_d, ed_y_d, ed_z_d;
  logic signed [CrossW-1:0] n_x_q, n_y_q, n_z_q, n_x_d, n_y_d, n_z_d;
  status_e st_q, st_d;
  logic [2:0] res_st_q;
  logic signed [NormW-1:0] res_x_q, res_y_q, res_z_q;

  logic in_xfer, out_xfer;
  assign in_stall_o = (state_q != S_LOAD);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_xfer   = out_valid_o && !out_stall_i;

  // Vertex store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (in_xfer && count_q < CntW'(MAX_VERTICES)) begin
      store_mem[count_q[IdxW-1:0]] <= {vert_x_i, vert_y_i, vert_z_i};
    end
    rd_a_q <= store_mem[ra_idx];
    rd_b_q <= store_mem[rb_idx];
  end

  function automatic logic signed [DiffW-1:0] dif(input logic [CoordW-1:0] a,
                                                    input logic [CoordW-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // Wrapped successor of an index.
  function automatic logic [CntW-1:0] nxt(input logic [CntW-1:0] k,
                                          input logic [CntW-1:0] n);
    return (k + CntW'(1) == n) ? '0 : k + CntW'(1);
  endfunction

  // Shared unit operands.
  logic dot_mode;
  logic signed [DiffW-1:0] ua_x, ua_y, ua_z, ub_x, ub_y, ub_z;
  logic signed [CrossW-1:0] un_x, un_y, un_z, uc_x, uc_y, uc_z;
  logic signed [DotW-1:0] udot;

  cppc_vec_unit u_vec (
    .clk_i      (clk_i),
    .dot_mode_i (dot_mode),
    .a_x_i (ua_x), .a_y_i (ua_y), .a_z_i (ua_z),
    .b_x_i (ub_x), .b_y_i (ub_y), .b_z_i (ub_z),
    .n_x_i (un_x), .n_y_i (un_y), .n_z_i (un_z),
    .c_x_o (uc_x), .c_y_o (uc_y), .c_z_o (uc_z),
    .dot_o (udot)
  );

  // Read addresses follow the sequencer indexes.
  always_comb begin
    ra_idx = i_q[IdxW-1:0];
    rb_idx = j_q[IdxW-1:0];
  end

  // Planarity uses the unit as a plain dot n . (vj - v0).
  assign dot_mode = (state_q == S_PLN);

  // Operand selection for the shared unit.
  always_comb begin
    ua_x = ed_x_q; ua_y = ed_y_q; ua_z = ed_z_q;
    ub_x = dif(rd_b_q[3*CoordW-1:2*CoordW], es_q[3*CoordW-1:2*CoordW]);
    ub_y = dif(rd_b_q[2*CoordW-1:CoordW],   es_q[2*CoordW-1:CoordW]);
    ub_z = dif(rd_b_q[CoordW-1:0],          es_q[CoordW-1:0]);
    un_x = n_x_q; un_y = n_y_q; un_z = n_z_q;
  end

  // Sequencer next state and data updates.
  always_comb begin
    state_d = state_q; count_d = count_q; ovf_d = ovf_q;
    i_d = i_q; j_d = j_q; ph_d = ph_q; es_d = es_q;
    ed_x_d = ed_x_q; ed_y_d = ed_y_q; ed_z_d = ed_z_q;
    n_x_d = n_x_q; n_y_d = n_y_q; n_z_d = n_z_q; st_d = st_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          if (count_q < CntW'(MAX_VERTICES)) count_d = count_q + CntW'(1);
          else ovf_d = 1'b1;
          if (last_vertex_i) begin
            n_x_d = '0; n_y_d = '0; n_z_d = '0;
            i_d = '0; j_d = CntW'(1); ph_d = '0;
            if (ovf_d) begin
              st_d = ST_MANY; state_d = S_DONE;
            end else if (count_d < CntW'(3)) begin
              st_d = ST_FEW; state_d = S_DONE;
            end else begin
              j_d = nxt('0, count_d); state_d = S_DUPRD;
            end
          end
        end
      end
      S_DUPRD: state_d = S_DUP;
      S_DUP: begin
        if (rd_a_q == rd_b_q) begin
          st_d = ST_DUP; state_d = S_DONE;
        end else if (i_q + CntW'(1) == count_q) begin
          // next: normal search, edge v1-v0 against vk-v0
          i_d = '0; j_d = CntW'(1); ph_d = '0; state_d = S_NRM;
        end else begin
          i_d = i_q + CntW'(1); j_d = nxt(i_q + CntW'(1), count_q);
          state_d = S_DUPRD;
        end
      end
      S_NRM: begin
        // ph 0: read v0, v1, point j at v2; 1: latch v0 and v1-v0;
        // 2: rd_b holds vj, unit crosses, j runs one ahead;
        // 3: cross of candidate j-1 registered -> test
        unique case (ph_q)
          2'd0: begin
            j_d = CntW'(2); ph_d = 2'd1;
          end
          2'd1: begin
            es_d = rd_a_q;
            ed_x_d = dif(rd_b_q[3*CoordW-1:2*CoordW], rd_a_q[3*CoordW-1:2*CoordW]);
            ed_y_d = dif(rd_b_q[2*CoordW-1:CoordW],   rd_a_q[2*CoordW-1:CoordW]);
            ed_z_d = dif(rd_b_q[CoordW-1:0],          rd_a_q[CoordW-1:0]);
            ph_d = 2'd2;
          end
          2'd2: begin
            j_d = j_q + CntW'(1); ph_d = 2'd3;
          end
          default: begin
            if (uc_x != '0 || uc_y != '0 || uc_z != '0) begin
              n_x_d = uc_x; n_y_d = uc_y; n_z_d = uc_z;
              j_d = '0; ph_d = '0; state_d = S_PLN;
            end else if (j_q == count_q) begin
              st_d = ST_DEGEN; state_d = S_DONE;
            end else begin
              ph_d = 2'd2;
            end
          end
        endcase
      end
      S_PLN: begin
        // ph 0: read vj; 1: latch vj - v0; 2: dot with normal; 3: test
        unique case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: ph_d = 2'd2;
          2'd2: ph_d = 2'd3;
          default: begin
            if (udot != '0) begin
              st_d = ST_NONPLANAR; state_d = S_DONE;
            end else if (j_q + CntW'(1) == count_q) begin
              i_d = '0; j_d = CntW'(1); ph_d = '0; state_d = S_EDGE;
            end else begin
              j_d = j_q + CntW'(1); ph_d = '0;
            end
          end
        endcase
      end
      S_EDGE: begin
        // i = edge start, j = its successor; wait one read then latch
        if (ph_q == 2'd0) ph_d = 2'd1;
        else begin
          es_d = rd_a_q;
          ed_x_d = dif(rd_b_q[3*CoordW-1:2*CoordW], rd_a_q[3*CoordW-1:2*CoordW]);
          ed_y_d = dif(rd_b_q[2*CoordW-1:CoordW],   rd_a_q[2*CoordW-1:CoordW]);
          ed_z_d = dif(rd_b_q[CoordW-1:0],          rd_a_q[CoordW-1:0]);
          j_d = '0; ph_d = '0; state_d = S_CVX;
        end
      end
      S_CVX: begin
        // ph 0: read vj; 1: cross; 2: dot; 3: test
        unique case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: ph_d = 2'd2;
          2'd2: ph_d = 2'd3;
          default: begin
            if (j_q != i_q && j_q != nxt(i_q, count_q) && udot < 0) begin
              st_d = ST_CONCAVE; state_d = S_DONE;
            end else if (j_q + CntW'(1) != count_q) begin
              j_d = j_q + CntW'(1); ph_d = '0;
            end else if (i_q + CntW'(1) != count_q) begin
              i_d = i_q + CntW'(1); j_d = nxt(i_q + CntW'(1), count_q);
              ph_d = '0; state_d = S_EDGE;
            end else begin
              st_d = ST_OK; state_d = S_DONE;
            end
          end
        endcase
      end
      S_DONE: state_d = S_OUT;
      S_OUT: begin
        if (out_xfer) state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
    if (state_q == S_DONE) begin
      count_d = '0; ovf_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; ph_q <= ph_d; es_q <= es_d;
    ed_x_q <= ed_x_d; ed_y_q <= ed_y_d; ed_z_q <= ed_z_d;
    n_x_q <= n_x_d; n_y_q <= n_y_d; n_z_q <= n_z_d; st_q <= st_d;
  end

  // Result register, latched once per polygon.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE) begin
      res_st_q <= st_q;
      if (st_q == ST_OK || st_q == ST_NONPLANAR || st_q == ST_CONCAVE) begin
        res_x_q <= n_x_q[NormW-1:0];
        res_y_q <= n_y_q[NormW-1:0];
        res_z_q <= n_z_q[NormW-1:0];
      end else begin
        res_x_q <= '0; res_y_q <= '0; res_z_q <= '0;
      end
    end
  end

  assign check_status_o = res_st_q;
  assign normal_x_o = res_x_q;
  assign normal_y_o = res_y_q;
  assign normal_z_o = res_z_q;

  // Input is never taken while an undelivered result is pending.
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during result");
  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(check_status_o))
    else $error("result changed under stall");
  // Count never exceeds the store depth.
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_VERTICES)) else $error("count overflow");
  // Store is empty once a result is presented.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> count_q == '0 && !ovf_q) else $error("not cleared");
endmodule
